// File: hdl/elc_pkg.sv
// Package for the extent layout overlap checker.
// Holds status codes, register indexes, default sizes and the cell control struct.
// No dependencies.
package elc_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_EXTENTS_DEF = 16;
    localparam int LBA_BITS_DEF    = 48;

    // fixed register and port widths
    localparam int DISK_BITS  = 49;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 64;

    // layout status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DEVICE = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_TOO_MANY  = 2'd3;

    // configuration register indexes (paddr[4:3])
    localparam logic [1:0] REG_PRESENT = 2'd0;
    localparam logic [1:0] REG_SLICE   = 2'd1;
    localparam logic [1:0] REG_DISK    = 2'd2;

    // control handed from the sequencer to every cell of the chain
    typedef struct packed {
        logic cmp;    // compare the pending extent against the held one
        logic shift;  // take the neighbor's extent
    } t_cell_ctl;

endpackage

// File: hdl/elc_cell.sv
// One cell of the extent chain: holds one stored extent and checks it for overlap.
// Depends on elc_pkg (t_cell_ctl).
module elc_cell import elc_pkg::*; #(
    parameter int LBA_BITS = LBA_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_ctl           i_ctl,
    input  logic                i_active,
    input  logic [LBA_BITS-1:0] i_new_start,
    input  logic [LBA_BITS-1:0] i_new_length,
    input  logic [LBA_BITS-1:0] i_prev_start,
    input  logic [LBA_BITS-1:0] i_prev_length,
    output logic [LBA_BITS-1:0] o_start,
    output logic [LBA_BITS-1:0] o_length,
    output logic                o_hit
);

    logic [LBA_BITS-1:0] r_start;
    logic [LBA_BITS-1:0] r_length;
    logic                r_hit;
    logic [LBA_BITS-1:0] w_diff_ab;
    logic [LBA_BITS-1:0] w_diff_ba;
    logic                w_a_after;
    logic                w_b_after;

    // half-open overlap test without forming start + length
    assign w_diff_ab = i_new_start - r_start;
    assign w_diff_ba = r_start - i_new_start;
    assign w_a_after = (i_new_start >= r_start) && (w_diff_ab >= r_length);
    assign w_b_after = (r_start >= i_new_start) && (w_diff_ba >= i_new_length);

    // hold the hit flag for the decision cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_hit <= i_active && !w_a_after && !w_b_after;
        end
    end

    // advance the stored extent along the chain
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_start  <= i_prev_start;
            r_length <= i_prev_length;
        end
    end

    assign o_start  = r_start;
    assign o_length = r_length;
    assign o_hit    = r_hit;

endmodule

// File: hdl/extent_layout_overlap_checker.sv
// Extent layout overlap checker: top level with sequencer, config port and cell chain.
// A closing word's status is registered at the end of its decide step.
// Per extent: capture, parallel compare in all cells, decide, then the next word is taken;
// a pending unaccepted status stalls the decide step of a closing word.
// Reset (synchronous, active low) clears the device registers, extent count and plan error.
// Depends on elc_pkg and elc_cell.
module extent_layout_overlap_checker import elc_pkg::*; #(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int LBA_BITS    = LBA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [LBA_BITS-1:0]  i_extent_start,
    input  logic [LBA_BITS-1:0]  i_extent_length,
    input  logic                 i_final_extent,
    input  logic                 i_empty_plan,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [1:0]           o_layout_status,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    localparam int HW = $clog2(MAX_EXTENTS + 1);
    localparam int RW = ((LBA_BITS > DISK_BITS) ? LBA_BITS : DISK_BITS) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [LBA_BITS-1:0]  r_start;
    logic [LBA_BITS-1:0]  r_length;
    logic                 r_final;
    logic                 r_empty;
    logic                 r_range_bad;
    logic [HW-1:0]        r_held, n_held;
    logic [1:0]           r_err, n_err;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_status, n_status;
    logic                 r_present;
    logic                 r_slice;
    logic [DISK_BITS-1:0] r_disk;

    t_cell_ctl            w_ctl;
    logic [MAX_EXTENTS-1:0] w_hit;
    logic [LBA_BITS-1:0]  w_st_start  [MAX_EXTENTS];
    logic [LBA_BITS-1:0]  w_st_length [MAX_EXTENTS];
    logic [RW-1:0]        w_start_x;
    logic [RW-1:0]        w_len_x;
    logic [RW-1:0]        w_disk_x;
    logic                 w_range_bad;
    logic                 w_cfg_wr;
    logic                 w_decide;
    logic                 w_closing;
    logic [1:0]           w_err_take;
    logic                 w_store;

    // configuration writes and reads
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_slice   <= 1'b0;
            r_disk    <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[4:3])
                REG_PRESENT: r_present <= pwdata[0];
                REG_SLICE:   r_slice   <= pwdata[0];
                REG_DISK:    r_disk    <= pwdata[DISK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_PRESENT: prdata = {{(DATA_BITS-1){1'b0}}, r_present};
            REG_SLICE:   prdata = {{(DATA_BITS-1){1'b0}}, r_slice};
            REG_DISK:    prdata = {{(DATA_BITS-DISK_BITS){1'b0}}, r_disk};
            default:     prdata = '0;
        endcase
    end

    // capture the accepted word
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_start  <= i_extent_start;
            r_length <= i_extent_length;
            r_final  <= i_final_extent;
            r_empty  <= i_empty_plan;
        end
    end

    // range check against the disk, registered for the decide step
    assign w_start_x   = RW'(r_start);
    assign w_len_x     = RW'(r_length);
    assign w_disk_x    = RW'(r_disk);
    assign w_range_bad = (r_length == '0) || (w_start_x >= w_disk_x)
                         || (w_len_x > (w_disk_x - w_start_x));

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHK) begin
            r_range_bad <= w_range_bad;
        end
    end

    // decide: first error wins, else store the extent at the head of the chain;
    // only a closing word waits for the status register to free up
    assign w_closing = r_empty || r_final;
    assign w_decide  = (r_state == S_RES) && (!w_closing || !r_out_valid || i_ready);

    always_comb begin
        w_err_take = r_err;
        w_store    = 1'b0;
        if (!r_empty && (r_err == ST_OK)) begin
            if (r_held >= HW'(MAX_EXTENTS)) begin
                w_err_take = ST_TOO_MANY;
            end else if (r_range_bad || (|w_hit)) begin
                w_err_take = ST_RANGE;
            end else begin
                w_store = 1'b1;
            end
        end
    end

    assign w_ctl.cmp   = (r_state == S_CHK);
    assign w_ctl.shift = w_decide && w_store;

    // sequencer and plan state
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (w_decide) begin
                    n_state = S_IDLE;
                    n_err   = w_err_take;
                    if (w_store) begin
                        n_held = r_held + HW'(1);
                    end
                    if (w_closing) begin
                        n_held      = '0;
                        n_err       = ST_OK;
                        n_out_valid = 1'b1;
                        if (!r_present) begin
                            n_status = ST_NO_DEVICE;
                        end else if (r_slice) begin
                            n_status = ST_RANGE;
                        end else begin
                            n_status = w_err_take;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    assign o_valid         = r_out_valid;
    assign o_layout_status = r_status;

    // chain of extent cells; cell 0 takes the new extent, the rest shift along
    for (genvar g = 0; g < MAX_EXTENTS; g++) begin : g_cell
        logic [LBA_BITS-1:0] w_prev_start;
        logic [LBA_BITS-1:0] w_prev_length;

        if (g == 0) begin : g_head
            assign w_prev_start  = r_start;
            assign w_prev_length = r_length;
        end else begin : g_body
            assign w_prev_start  = w_st_start[g-1];
            assign w_prev_length = w_st_length[g-1];
        end

        elc_cell #(
            .LBA_BITS(LBA_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_active      (r_held > HW'(g)),
            .i_new_start   (r_start),
            .i_new_length  (r_length),
            .i_prev_start  (w_prev_start),
            .i_prev_length (w_prev_length),
            .o_start       (w_st_start[g]),
            .o_length      (w_st_length[g]),
            .o_hit         (w_hit[g])
        );
    end

endmodule
